// ===== sv/sha256_pkg.sv =====
// ============================================================================
// SHA-256 package
// Shared types, constants and a rotate function for the byte stream hasher.
// ============================================================================
package sha256_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_POS     = 56;
    localparam int unsigned ROUNDS      = 64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUNDS,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } t_state;

    // Byte source for a buffer write
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD80,
        SRC_ZERO,
        SRC_LEN
    } t_src;

    typedef struct packed {
        logic       buf_wr;
        t_src       src;
        logic       fill_inc;
        logic       fill_clr;
        logic       start_block;
        logic       round;
        logic       update;
        logic       add_512;
        logic       latch_total;
        logic       reset_msg;
        logic       emit_load;
        logic       emit_next;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       rounds_done;
        logic       last_emit;
    } t_status;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/sha256_byte_stream_hash.sv =====
// ============================================================================
// SHA-256 byte stream hash
// Top level: controller plus datapath.
// ============================================================================
// One byte per transfer is taken into a 64-byte block held as the 16-word
// message schedule. The 64th byte of a block starts the compression: 64
// rounds, one round per cycle, then the chaining update, with input stalled
// until the block is done. An end transfer pads the block one byte per
// cycle (and an extra block when the length does not fit), runs the rounds,
// then presents the eight digest words, one per output transfer, and
// returns to the initial chaining values.
module sha256_byte_stream_hash (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  sha256_pkg::t_in_item  i_in_item,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sha256_pkg::t_out_item o_out_item
);
    import sha256_pkg::*;

    t_cmd    cmd;
    t_status status;

    sha256_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sha256_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data_byte(i_in_item.data_byte),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );
endmodule

// ===== sv/sha256_datapath.sv =====
// ============================================================================
// SHA-256 datapath
// Block buffer as a 16-word schedule shift line, working registers, chaining
// words, length counter and digest output register.
// ============================================================================
module sha256_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_data_byte,
    input  sha256_pkg::t_cmd      i_cmd,
    output sha256_pkg::t_status   o_status,
    output sha256_pkg::t_out_item o_out_item
);
    import sha256_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_total;
    logic [5:0]  r_round;
    logic [2:0]  r_oidx;

    logic [7:0]  wr_byte;
    logic [31:0] w_new, s0, s1, t1, t2;

    always_comb begin
        case (i_cmd.src)
            SRC_DATA:  wr_byte = i_data_byte;
            SRC_PAD80: wr_byte = 8'h80;
            SRC_ZERO:  wr_byte = 8'h00;
            SRC_LEN:   wr_byte = r_total[63 - 8*(r_fill[2:0]) -: 8];
            default:   wr_byte = 8'h00;
        endcase
        s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
            + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + K_TAB[r_round] + r_w[0];
        t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
            + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Bytes shift in at the tail; after 64 bytes word 0 is the first word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.buf_wr) begin
            if (r_fill[1:0] == 2'd0) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= {r_w[15][23:0], wr_byte};
            end else begin
                r_w[15] <= {r_w[15][23:0], wr_byte};
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
        if (i_cmd.start_block) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_cmd.latch_total) r_total <= r_bits + {55'd0, r_fill, 3'd0};
        if (i_cmd.emit_load) begin
            o_out_item <= '{digest_word: r_h[0], word_index: 3'd0, last_word: 1'b0};
        end else if (i_cmd.emit_next) begin
            o_out_item <= '{digest_word: r_h[r_oidx], word_index: r_oidx,
                            last_word: (r_oidx == 3'd7)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
            r_fill  <= '0;
            r_bits  <= '0;
            r_round <= '0;
            r_oidx  <= '0;
        end else begin
            if (i_cmd.fill_clr)      r_fill <= '0;
            else if (i_cmd.fill_inc) r_fill <= r_fill + 6'd1;
            if (i_cmd.start_block)   r_round <= '0;
            else if (i_cmd.round)    r_round <= r_round + 6'd1;
            if (i_cmd.reset_msg) begin
                for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
                r_bits <= '0;
            end else begin
                if (i_cmd.update)
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                if (i_cmd.add_512) r_bits <= r_bits + 64'd512;
            end
            if (i_cmd.emit_load)      r_oidx <= 3'd1;
            else if (i_cmd.emit_next) r_oidx <= r_oidx + 3'd1;
        end
    end

    assign o_status.fill        = r_fill;
    assign o_status.rounds_done = (r_round == 6'(ROUNDS - 1));
    assign o_status.last_emit   = o_out_item.last_word;

`ifndef SYNTHESIS
    a_fill_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_clr |=> r_fill == 6'd0) else $error("fill not cleared");
    a_round_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round && !i_cmd.start_block |=> r_round == $past(r_round) + 6'd1)
        else $error("round counter");
    a_reset_h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.reset_msg |=> r_h[0] == H_INIT[0] && r_bits == 64'd0)
        else $error("chain not reset");
`endif
endmodule

// ===== sv/sha256_ctrl.sv =====
// ============================================================================
// SHA-256 controller
// Sequences byte loading, rounds, padding and digest emission.
// ============================================================================
module sha256_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  sha256_pkg::t_in_item i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  sha256_pkg::t_status  i_status,
    output sha256_pkg::t_cmd     o_cmd
);
    import sha256_pkg::*;

    t_state r_state, n_state;
    logic   r_final, n_final;   // finishing the message
    logic   r_lendone, n_lendone; // length block written
    logic   r_padded, n_padded; // 0x80 byte written
    logic   r_ovf, n_ovf;       // length does not fit in the current block
    logic   r_ovalid, n_ovalid;
    logic   acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_final   <= 1'b0;
            r_lendone <= 1'b0;
            r_padded  <= 1'b0;
            r_ovf     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_final   <= n_final;
            r_lendone <= n_lendone;
            r_padded  <= n_padded;
            r_ovf     <= n_ovf;
            r_ovalid  <= n_ovalid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign acc         = i_in_valid && !o_in_stall;

    always_comb begin
        n_state   = r_state;
        n_final   = r_final;
        n_lendone = r_lendone;
        n_padded  = r_padded;
        n_ovf     = r_ovf;
        n_ovalid  = r_ovalid;
        o_cmd     = '0;
        o_cmd.src = SRC_DATA;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_in_item.byte_valid) begin
                        o_cmd.buf_wr   = 1'b1;
                        o_cmd.fill_inc = 1'b1;
                    end
                    if (i_in_item.byte_valid && i_status.fill == 6'd63) begin
                        n_state = ST_ROUNDS;
                        o_cmd.start_block = 1'b1;
                        o_cmd.add_512 = 1'b1;
                        n_final = i_in_item.end_of_message;
                        n_lendone = 1'b0;
                    end else if (i_in_item.end_of_message) begin
                        n_state = ST_PAD;
                        n_final = 1'b1;
                        n_lendone = 1'b0;
                    end
                end
            end
            ST_PAD: begin
                // first pad cycle: total taken before the 0x80 byte
                o_cmd.buf_wr   = 1'b1;
                o_cmd.fill_inc = 1'b1;
                o_cmd.latch_total = 1'b1;
                o_cmd.src = SRC_PAD80;
                n_state = ST_UPDATE;
                n_lendone = 1'b0;
                n_padded = 1'b1;
                n_ovf = (i_status.fill >= 6'(LEN_POS)) && (i_status.fill != 6'd63);
                if (i_status.fill == 6'd63) begin
                    o_cmd.start_block = 1'b1;
                    n_state = ST_ROUNDS;
                end else begin
                    n_state = ST_EMIT;
                    n_ovalid = 1'b0;
                end
            end
            ST_EMIT: begin
                // reused as zero/length fill while not yet emitting
                if (!r_lendone) begin
                    o_cmd.buf_wr   = 1'b1;
                    o_cmd.fill_inc = 1'b1;
                    o_cmd.src = (i_status.fill >= 6'(LEN_POS) && !r_ovf) ?
                                SRC_LEN : SRC_ZERO;
                    if (i_status.fill == 6'd63) begin
                        o_cmd.start_block = 1'b1;
                        n_lendone = !r_ovf;
                        n_ovf = 1'b0;
                        n_state = ST_ROUNDS;
                    end
                end else if (!r_ovalid) begin
                    o_cmd.emit_load = 1'b1;
                    n_ovalid = 1'b1;
                end else if (!i_out_stall) begin
                    if (i_status.last_emit) begin
                        n_ovalid = 1'b0;
                        n_final = 1'b0;
                        n_lendone = 1'b0;
                        n_padded = 1'b0;
                        n_ovf = 1'b0;
                        o_cmd.reset_msg = 1'b1;
                        o_cmd.fill_clr = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                    end
                end
            end
            ST_ROUNDS: begin
                o_cmd.round = 1'b1;
                if (i_status.rounds_done) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (!r_final)      n_state = ST_IDLE;
                else if (r_padded) n_state = ST_EMIT;
                else               n_state = ST_PAD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> o_in_stall) else $error("accept while busy");
    a_out_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == ST_EMIT) else $error("output outside emit");
    a_round_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_block |=> r_state == ST_ROUNDS) else $error("no rounds");
`endif
endmodule
